>>> hdl/assert_macros.svh
// Concurrent assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check prop on every rising edge while reset is released.
`define BPT_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check prop on every rising edge, reset included.
`define BPT_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BPT_ASSERT(name, clk, rst_n, prop, msg)
`define BPT_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

>>> hdl/bpt_pkg.sv
package bpt_pkg;

    localparam int BPT_NUM_SLOTS = 128;

    localparam logic [2:0] ST_UNKNOWN  = 3'd0;
    localparam logic [2:0] ST_FLASHING = 3'd1;

    localparam logic KIND_SET  = 1'b0;
    localparam logic KIND_FIND = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [6:0] address;
        logic [2:0] new_state;
        logic [6:0] index;
    } t_bpt_req;

    typedef struct packed {
        logic [7:0] present_total;
        logic [7:0] flashing_total;
        logic [6:0] found_address;
        logic [2:0] found_state;
    } t_bpt_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SET,
        S_WALK,
        S_FETCH,
        S_LATCH,
        S_DONE
    } t_bpt_fsm;

endpackage

>>> hdl/bpt_ram.sv
module bpt_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/bpt_table.sv
module bpt_table #(
    parameter int NUM_SLOTS = bpt_pkg::BPT_NUM_SLOTS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_we,
    input  logic [$clog2(NUM_SLOTS)-1:0] i_waddr,
    input  logic [2:0]                   i_wdata,
    input  logic                         i_re,
    input  logic [$clog2(NUM_SLOTS)-1:0] i_raddr,
    output logic [2:0]                   o_state
);
    import bpt_pkg::*;

    localparam int AW = $clog2(NUM_SLOTS);

    logic [NUM_SLOTS-1:0] r_vld;
    logic [AW-1:0]        r_raddr;
    logic [2:0]           ram_rdata;

    bpt_ram #(
        .WIDTH (3),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_re    (i_re),
        .i_raddr (i_raddr),
        .o_rdata (ram_rdata)
    );

    // An entry never written since reset reads as unknown.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_raddr <= i_raddr;
        end
    end

    assign o_state = r_vld[r_raddr] ? ram_rdata : ST_UNKNOWN;

endmodule

>>> hdl/board_presence_table_select.sv
// Channel   Direction  Handshake                  Beat
// request   in         i_req_valid / o_req_stall  i_req (set or find)
// response  out        o_rsp_valid / i_rsp_stall  o_rsp (totals, found entry)
//
// One item at a time. A set reads, modifies and writes its entry, then reads
// the reported entry; a set outside the table only does that last read. A find
// served from the search cache or rejected only reads the reported entry; a walk
// reads one table entry per cycle through the single read port.
// Reset is synchronous; per-entry valid bits make the whole table unknown at
// once, with no clearing pass. A finished beat waits in the output register
// while the next request is taken.
`include "assert_macros.svh"

module board_presence_table_select #(
    parameter int NUM_SLOTS = bpt_pkg::BPT_NUM_SLOTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_stall,
    input  bpt_pkg::t_bpt_req i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_stall,
    output bpt_pkg::t_bpt_rsp o_rsp
);
    import bpt_pkg::*;

    localparam int AW  = $clog2(NUM_SLOTS);
    localparam int WAW = AW + 1;
    localparam logic [WAW-1:0] SLOT_END = WAW'(NUM_SLOTS);

    t_bpt_fsm r_state, n_state;
    t_bpt_req r_req, n_req;
    logic [7:0]     r_pc, n_pc;
    logic [7:0]     r_fc, n_fc;
    logic [6:0]     r_cidx, n_cidx;
    logic [AW-1:0]  r_caddr, n_caddr;
    logic [WAW-1:0] r_waddr, n_waddr;
    logic           r_pend, n_pend;
    logic [AW-1:0]  r_chk, n_chk;
    logic [6:0]     r_wcnt, n_wcnt;
    logic [AW-1:0]  r_faddr, n_faddr;
    logic [2:0]     r_fstate, n_fstate;
    t_bpt_rsp       r_rsp, n_rsp;
    logic           r_rsp_vld, n_rsp_vld;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [2:0]    mem_wdata;
    logic [2:0]    rd_state;

    logic       req_acc, rsp_free;
    logic       set_in_range, cache_hit, find_none;
    logic       walk_present, walk_hit, walk_end;
    logic       start_clear;
    logic [6:0] start_idx;
    logic [AW-1:0] start_addr;

    bpt_table #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_state (rd_state)
    );

    assign o_req_stall = (r_state != S_IDLE);
    assign req_acc     = i_req_valid && !o_req_stall;
    assign rsp_free    = !r_rsp_vld || !i_rsp_stall;

    assign set_in_range = (9'(i_req.address) < 9'(NUM_SLOTS));
    assign cache_hit    = (i_req.index == r_cidx);
    assign find_none    = (i_req.index == 7'd0) || ({1'b0, i_req.index} > r_pc);
    assign start_clear  = (r_cidx > i_req.index);
    assign start_idx    = start_clear ? 7'd0 : r_cidx;
    assign start_addr   = start_clear ? '0 : r_caddr;

    assign walk_present = r_pend && (rd_state != ST_UNKNOWN);
    assign walk_hit     = walk_present && (r_wcnt + 7'd1 == r_req.index);
    assign walk_end     = (r_waddr >= SLOT_END);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    if (i_req.kind == KIND_SET) begin
                        n_state = set_in_range ? S_SET : S_FETCH;
                    end else begin
                        n_state = (cache_hit || find_none) ? S_FETCH : S_WALK;
                    end
                end
            end
            S_SET:   n_state = S_FETCH;
            S_WALK: begin
                if (walk_hit) begin
                    n_state = S_DONE;
                end else if (walk_end) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: n_state = S_LATCH;
            S_LATCH: n_state = S_DONE;
            S_DONE: begin
                if (rsp_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_req     = r_req;
        n_pc      = r_pc;
        n_fc      = r_fc;
        n_cidx    = r_cidx;
        n_caddr   = r_caddr;
        n_waddr   = r_waddr;
        n_pend    = r_pend;
        n_chk     = r_chk;
        n_wcnt    = r_wcnt;
        n_faddr   = r_faddr;
        n_fstate  = r_fstate;
        n_rsp     = r_rsp;
        n_rsp_vld = r_rsp_vld && i_rsp_stall;
        mem_we    = 1'b0;
        mem_waddr = AW'(r_req.address);
        mem_wdata = r_req.new_state;
        mem_re    = 1'b0;
        mem_raddr = r_faddr;
        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_req   = i_req;
                    n_faddr = '0;
                    if (i_req.kind == KIND_SET) begin
                        mem_re    = set_in_range;
                        mem_raddr = AW'(i_req.address);
                    end else if (cache_hit) begin
                        n_faddr = r_caddr;
                    end else if (!find_none) begin
                        // Drop the cache when the sought index lies before it.
                        n_cidx  = start_idx;
                        n_caddr = start_addr;
                        n_waddr = WAW'(start_addr) + WAW'(1);
                        n_wcnt  = start_idx;
                        n_pend  = 1'b0;
                    end
                end
            end
            S_SET: begin
                if (r_req.new_state != rd_state) begin
                    mem_we = 1'b1;
                    if (rd_state == ST_UNKNOWN) begin
                        if (r_pc != 8'd255) begin
                            n_pc = r_pc + 8'd1;
                        end
                        n_cidx  = '0;
                        n_caddr = '0;
                    end else if (r_req.new_state == ST_UNKNOWN && r_pc != 8'd0) begin
                        n_pc    = r_pc - 8'd1;
                        n_cidx  = '0;
                        n_caddr = '0;
                    end
                    if (rd_state == ST_FLASHING && r_fc != 8'd0) begin
                        n_fc = r_fc - 8'd1;
                    end else if (r_req.new_state == ST_FLASHING && r_fc != 8'd255) begin
                        n_fc = r_fc + 8'd1;
                    end
                end
            end
            S_WALK: begin
                if (walk_hit) begin
                    n_cidx   = r_req.index;
                    n_caddr  = r_chk;
                    n_faddr  = r_chk;
                    n_fstate = rd_state;
                end else begin
                    if (walk_present) begin
                        n_wcnt = r_wcnt + 7'd1;
                    end
                    // Keep one read in flight ahead of the check.
                    if (!walk_end) begin
                        mem_re    = 1'b1;
                        mem_raddr = r_waddr[AW-1:0];
                        n_chk     = r_waddr[AW-1:0];
                        n_pend    = 1'b1;
                        n_waddr   = r_waddr + WAW'(1);
                    end
                end
            end
            S_FETCH: begin
                mem_re    = 1'b1;
                mem_raddr = r_faddr;
            end
            S_LATCH: begin
                n_fstate = rd_state;
            end
            S_DONE: begin
                if (rsp_free) begin
                    n_rsp.present_total  = r_pc;
                    n_rsp.flashing_total = r_fc;
                    n_rsp.found_address  = 7'(r_faddr);
                    n_rsp.found_state    = r_fstate;
                    n_rsp_vld            = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pc      <= '0;
            r_fc      <= '0;
            r_cidx    <= '0;
            r_caddr   <= '0;
            r_pend    <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pc      <= n_pc;
            r_fc      <= n_fc;
            r_cidx    <= n_cidx;
            r_caddr   <= n_caddr;
            r_pend    <= n_pend;
            r_rsp_vld <= n_rsp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_waddr  <= n_waddr;
        r_chk    <= n_chk;
        r_wcnt   <= n_wcnt;
        r_faddr  <= n_faddr;
        r_fstate <= n_fstate;
        r_rsp    <= n_rsp;
    end

    assign o_rsp_valid = r_rsp_vld;
    assign o_rsp       = r_rsp;

    `BPT_ASSERT(a_accept_leaves_idle, i_clk, i_rst_n, req_acc |=> (r_state != S_IDLE), "request accepted but sequencer stayed idle")
    `BPT_ASSERT(a_walk_below_index, i_clk, i_rst_n, (r_state == S_WALK) |-> (r_wcnt < r_req.index), "walk count reached the sought index without a hit")
    `BPT_ASSERT(a_cache_clear_pair, i_clk, i_rst_n, (r_cidx == 7'd0) |-> (r_caddr == '0), "cleared cache index with a stale address")
    `BPT_ASSERT(a_count_from_set, i_clk, i_rst_n, ($past(i_rst_n) && !$stable(r_pc)) |-> ($past(r_state) == S_SET), "present count moved outside a set")

endmodule

>>> dv/board_presence_table_select_tb.sv
module board_presence_table_select_tb;

    import bpt_pkg::*;

    localparam logic [2:0] ST_RUNNING      = 3'd2;
    localparam logic [2:0] ST_RESETTING    = 3'd3;
    localparam logic [2:0] ST_FLASH_FAILED = 3'd4;
    localparam logic [2:0] ST_RESERVED     = 3'd7;

    localparam bit LITERAL = 1'b1;
    localparam bit PREDICT = 1'b0;

    localparam int RANDOM_BEATS = 1625;
    localparam int HOLD_START   = 1200;
    localparam int HOLD_CYCLES  = 600;
    localparam int MAX_REPORTS  = 100;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_PATTERN,
        STALL_RARE
    } t_stall_style;

    typedef struct {
        logic       kind;
        logic [6:0] address;
        logic [2:0] new_state;
        logic [6:0] index;
        bit         literal;
        logic [7:0] present;
        logic [7:0] flashing;
        logic [6:0] found_addr;
        logic [2:0] found_st;
    } t_directed_row;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_req_valid = 1'b0;
    t_bpt_req i_req       = '0;
    logic     i_rsp_stall = 1'b0;
    logic     o_req_stall;
    logic     o_rsp_valid;
    t_bpt_rsp o_rsp;

    // Table shadow, counts and search cache as the block should hold them.
    logic [2:0]  slot_state [BPT_NUM_SLOTS] = '{default: ST_UNKNOWN};
    int unsigned live_cnt  = 0;
    int unsigned flash_cnt = 0;
    int unsigned memo_idx  = 0;
    int unsigned memo_addr = 0;

    t_bpt_rsp offered_rsp_q [$];
    t_bpt_rsp awaited_rsp_q [$];
    int       mismatch_count = 0;
    int       burst_left     = 0;

    // kind, address, new_state, index, literal, present, flashing, found address, found state
    t_directed_row directed_rows [24] = '{
        '{KIND_FIND, 7'h7f, ST_RESERVED,     7'd0,   LITERAL, 8'd0, 8'd0, 7'd0,   ST_UNKNOWN},
        '{KIND_FIND, 7'd0,  ST_UNKNOWN,      7'd127, LITERAL, 8'd0, 8'd0, 7'd0,   ST_UNKNOWN},
        '{KIND_SET,  7'd127, ST_FLASHING,    7'h7f,  LITERAL, 8'd1, 8'd1, 7'd0,   ST_UNKNOWN},
        '{KIND_SET,  7'd127, ST_FLASHING,    7'd0,   LITERAL, 8'd1, 8'd1, 7'd0,   ST_UNKNOWN},
        '{KIND_FIND, 7'd0,  ST_UNKNOWN,      7'd1,   LITERAL, 8'd1, 8'd1, 7'd127, ST_FLASHING},
        '{KIND_FIND, 7'h7f, ST_RESERVED,     7'd1,   LITERAL, 8'd1, 8'd1, 7'd127, ST_FLASHING},
        '{KIND_SET,  7'd1,  ST_FLASH_FAILED, 7'd0,   LITERAL, 8'd2, 8'd1, 7'd0,   ST_UNKNOWN},
        '{KIND_FIND, 7'd0,  ST_UNKNOWN,      7'd2,   PREDICT, 8'd0, 8'd0, 7'd0,   ST_UNKNOWN},
        '{KIND_FIND, 7'h7f, ST_RESERVED,     7'd1,   PREDICT, 8'd0, 8'd0, 7'd0,   ST_UNKNOWN},
        '{KIND_SET,  7'd64, ST_RESERVED,     7'd0,   LITERAL, 8'd3, 8'd1, 7'd0,   ST_UNKNOWN},
        '{KIND_FIND, 7'd0,  ST_UNKNOWN,      7'd2,   PREDICT, 8'd0, 8'd0, 7'd0,   ST_UNKNOWN},
        '{KIND_SET,  7'd127, ST_RUNNING,     7'd0,   PREDICT, 8'd0, 8'd0, 7'd0,   ST_UNKNOWN},
        '{KIND_FIND, 7'd0,  ST_UNKNOWN,      7'd3,   PREDICT, 8'd0, 8'd0, 7'd0,   ST_UNKNOWN},
        '{KIND_SET,  7'd0,  ST_RESETTING,    7'h7f,  LITERAL, 8'd4, 8'd0, 7'd0,   ST_RESETTING},
        '{KIND_FIND, 7'd0,  ST_UNKNOWN,      7'd4,   LITERAL, 8'd4, 8'd0, 7'd0,   ST_RESETTING},
        '{KIND_FIND, 7'd0,  ST_UNKNOWN,      7'd3,   PREDICT, 8'd0, 8'd0, 7'd0,   ST_UNKNOWN},
        '{KIND_SET,  7'd64, ST_UNKNOWN,      7'd0,   PREDICT, 8'd0, 8'd0, 7'd0,   ST_UNKNOWN},
        '{KIND_FIND, 7'd0,  ST_UNKNOWN,      7'd0,   LITERAL, 8'd3, 8'd0, 7'd0,   ST_RESETTING},
        '{KIND_SET,  7'd0,  ST_UNKNOWN,      7'd0,   PREDICT, 8'd0, 8'd0, 7'd0,   ST_UNKNOWN},
        '{KIND_SET,  7'd127, ST_FLASHING,    7'd0,   PREDICT, 8'd0, 8'd0, 7'd0,   ST_UNKNOWN},
        '{KIND_SET,  7'd1,  ST_FLASHING,     7'd0,   PREDICT, 8'd0, 8'd0, 7'd0,   ST_UNKNOWN},
        '{KIND_SET,  7'd127, ST_UNKNOWN,     7'd0,   PREDICT, 8'd0, 8'd0, 7'd0,   ST_UNKNOWN},
        '{KIND_FIND, 7'd0,  ST_UNKNOWN,      7'd1,   PREDICT, 8'd0, 8'd0, 7'd0,   ST_UNKNOWN},
        '{KIND_FIND, 7'h7f, ST_RESERVED,     7'd2,   LITERAL, 8'd1, 8'd1, 7'd0,   ST_UNKNOWN}
    };

    board_presence_table_select dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 0;
    end

    function automatic t_bpt_rsp step_presence_table(input t_bpt_req req);
        logic [2:0]  prior;
        int unsigned found;
        int unsigned walk_addr;
        int unsigned walk_cnt;
        bit          ran_off;
        t_bpt_rsp    rsp;
        found = 0;
        if (req.kind == KIND_SET) begin
            prior = slot_state[req.address];
            if (req.new_state != prior) begin
                slot_state[req.address] = req.new_state;
                if (prior == ST_UNKNOWN) begin
                    if (live_cnt < 255) live_cnt++;
                    memo_idx  = 0;
                    memo_addr = 0;
                end else if (prior == ST_FLASHING && flash_cnt != 0) begin
                    flash_cnt--;
                end
                if (req.new_state == ST_FLASHING) begin
                    if (flash_cnt < 255) flash_cnt++;
                end else if (req.new_state == ST_UNKNOWN && live_cnt != 0) begin
                    live_cnt--;
                    memo_idx  = 0;
                    memo_addr = 0;
                end
            end
        end else if (req.index == memo_idx) begin
            found = memo_addr;
        end else if (req.index != 0 && req.index <= live_cnt) begin
            if (memo_idx > req.index) begin
                memo_idx  = 0;
                memo_addr = 0;
            end
            walk_addr = memo_addr;
            walk_cnt  = memo_idx;
            ran_off   = 1'b0;
            // slot 0 never counts; running past the top leaves the cache as it stands
            while (walk_cnt < req.index && !ran_off) begin
                walk_addr++;
                if (walk_addr >= BPT_NUM_SLOTS)
                    ran_off = 1'b1;
                else if (slot_state[walk_addr] != ST_UNKNOWN)
                    walk_cnt++;
            end
            if (!ran_off) begin
                memo_idx  = req.index;
                memo_addr = walk_addr;
                found     = walk_addr;
            end
        end
        rsp.present_total  = 8'(live_cnt);
        rsp.flashing_total = 8'(flash_cnt);
        rsp.found_address  = 7'(found);
        rsp.found_state    = slot_state[found];
        return rsp;
    endfunction

    // Half sets, half finds; finds mostly well-formed around the cache and the live count; density alternates.
    function automatic t_bpt_req pick_random_beat(input int n);
        t_bpt_req req;
        int       roll;
        int       unknown_pct;
        int       hi;
        req.kind      = 1'($urandom);
        req.address   = 7'($urandom);
        req.new_state = 3'($urandom);
        req.index     = 7'($urandom);
        unknown_pct   = ((n / 250) % 2 == 1) ? 55 : 12;
        roll          = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 50) begin
            req.kind = KIND_SET;
            if (roll < 6)
                req.address = '0;
            else if (roll < 16)
                req.address = 7'($urandom_range(120, 127));
            roll = $urandom_range(0, 99);
            if (roll < 8)
                req.new_state = slot_state[req.address];
            else if (roll < 8 + unknown_pct)
                req.new_state = ST_UNKNOWN;
            else if (roll < 8 + unknown_pct + (92 - unknown_pct) / 3)
                req.new_state = ST_FLASHING;
            else if (roll < 95)
                req.new_state = 3'($urandom_range(ST_RUNNING, ST_FLASH_FAILED));
            else
                req.new_state = 3'($urandom_range(5, ST_RESERVED));
        end else begin
            req.kind = KIND_FIND;
            hi = (live_cnt == 0) ? 1 : int'(live_cnt);
            if (roll < 15)
                req.index = 7'(memo_idx);
            else if (roll < 40)
                req.index = 7'(memo_idx + 1);
            else if (roll < 50)
                req.index = 7'($urandom_range(0, memo_idx));
            else if (roll < 75)
                req.index = 7'($urandom_range(1, hi));
            else if (roll < 82)
                req.index = '0;
            else if (roll < 92)
                req.index = 7'($urandom_range((live_cnt >= 127) ? 127 : live_cnt + 1, 127));
        end
        return req;
    endfunction

    task automatic log_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            log_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // Hold the beat until taken; start a new burst after a random gap, which may be zero.
    task automatic offer_beat(input t_bpt_req req);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 16);
            if (gap != 0) begin
                i_req_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_req_valid <= 1'b1;
        i_req       <= req;
        do @(posedge i_clk); while (o_req_stall);
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_bpt_rsp want;
        if (i_rst_n) begin
            if (i_req_valid && !o_req_stall && offered_rsp_q.size() != 0)
                awaited_rsp_q.push_back(offered_rsp_q.pop_front());
            if (o_rsp_valid && !i_rsp_stall) begin
                if (awaited_rsp_q.size() == 0) begin
                    log_mismatch($sformatf("result beat %h with nothing outstanding", o_rsp));
                end else begin
                    want = awaited_rsp_q.pop_front();
                    check_field("present_total", o_rsp.present_total, want.present_total);
                    check_field("flashing_total", o_rsp.flashing_total, want.flashing_total);
                    check_field("found_address", 8'(o_rsp.found_address),
                                8'(want.found_address));
                    check_field("found_state", 8'(o_rsp.found_state), 8'(want.found_state));
                end
            end
        end
    end

    initial begin : receiver
        int           cyc;
        t_stall_style style;
        cyc   = 0;
        style = STALL_NONE;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 97 == 0)
                style = t_stall_style'($urandom_range(0, 3));
            // one long hold-off so the block backs up into its request side
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES)
                i_rsp_stall <= 1'b1;
            else
                case (style)
                    STALL_NONE:    i_rsp_stall <= 1'b0;
                    STALL_COIN:    i_rsp_stall <= 1'($urandom);
                    STALL_PATTERN: i_rsp_stall <= (cyc % 5 < 3);
                    default:       i_rsp_stall <= ($urandom_range(0, 7) == 0);
                endcase
        end
    end

    initial begin : stimulus
        t_bpt_req req;
        t_bpt_rsp pred;
        t_bpt_rsp lit;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[r]) begin
            req.kind      = directed_rows[r].kind;
            req.address   = directed_rows[r].address;
            req.new_state = directed_rows[r].new_state;
            req.index     = directed_rows[r].index;
            pred          = step_presence_table(req);
            if (directed_rows[r].literal) begin
                lit.present_total  = directed_rows[r].present;
                lit.flashing_total = directed_rows[r].flashing;
                lit.found_address  = directed_rows[r].found_addr;
                lit.found_state    = directed_rows[r].found_st;
                offered_rsp_q.push_back(lit);
            end else begin
                offered_rsp_q.push_back(pred);
            end
            offer_beat(req);
        end
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            req = pick_random_beat(n);
            offered_rsp_q.push_back(step_presence_table(req));
            offer_beat(req);
        end
        i_req_valid <= 1'b0;
        while (offered_rsp_q.size() != 0 || awaited_rsp_q.size() != 0)
            @(posedge i_clk);
        // drain: catch any stray beat
        repeat (BPT_NUM_SLOTS + 8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/bpt_pkg.sv
hdl/bpt_ram.sv
hdl/bpt_table.sv
hdl/board_presence_table_select.sv
dv/board_presence_table_select_tb.sv
